### src/brt_pkg.sv
// shared types and constants for the binary trie route lookup
`timescale 1ns / 1ps

package brt_pkg;

	localparam int NODE_COUNT_DEF = 4096;
	localparam int ADDR_BITS = 32;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_MATCH   = 2'd1,
		ST_TABLE_FULL = 2'd2,
		ST_BAD_LENGTH = 2'd3
	} status_t;

	typedef struct packed {
		logic load;
		logic walk;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic done;
	} ctrl_sts_t;

endpackage

### src/brt_ctrl.sv
// sequencing state machine for the trie walk
`timescale 1ns / 1ps

module brt_ctrl import brt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_WALK   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	always_comb begin
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.walk = (state_q == S_WALK);
		cmd.emit = (state_q == S_FINISH) && (!out_valid_q || !out_stall);
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_WALK;
			end
			S_WALK: begin
				if (sts.done) state_nxt = S_FINISH;
			end
			S_FINISH: begin
				if (cmd.emit) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

### src/brt_datapath.sv
// node store, walk registers and result registers of the trie
`timescale 1ns / 1ps

module brt_datapath import brt_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_cmd_t   cmd,
	output ctrl_sts_t   sts,
	input  logic        operation,
	input  logic [31:0] address,
	input  logic [5:0]  mask_len,
	input  logic [15:0] next_hop,
	output logic [1:0]  status,
	output logic [15:0] port_found
);

	localparam int IW = $clog2(NODE_COUNT);
	localparam int FW = $clog2(NODE_COUNT + 1);
	localparam logic [FW-1:0] FULL_COUNT = FW'(NODE_COUNT);
	localparam logic [5:0] LEVEL_MAX = 6'(ADDR_BITS);

	// node zero lives in flops so reset clears its links and flag; other nodes are
	// initialized when the bump counter hands them out
	logic [IW-1:0] left_mem  [NODE_COUNT];
	logic [IW-1:0] right_mem [NODE_COUNT];
	logic          has_mem   [NODE_COUNT];
	logic [15:0]   port_mem  [NODE_COUNT];

	logic                 op_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [5:0]           len_q;
	logic [15:0]          hop_q;
	logic [IW-1:0]        node_q;
	logic [5:0]           level_q;
	logic                 fresh_q;
	logic                 found_q;
	logic [15:0]          best_q;
	logic [FW-1:0]        next_free_q;
	logic [IW-1:0]        root_left_q;
	logic [IW-1:0]        root_right_q;
	logic                 root_has_q;
	logic [15:0]          root_port_q;
	logic [IW-1:0]        rd_left_q;
	logic [IW-1:0]        rd_right_q;
	logic                 rd_has_q;
	logic [15:0]          rd_port_q;
	status_t              res_status_q;
	logic [15:0]          res_port_q;
	logic [1:0]           status_q;
	logic [15:0]          port_q;

	logic          at_root;
	logic [IW-1:0] cur_left;
	logic [IW-1:0] cur_right;
	logic          cur_has;
	logic [15:0]   cur_port;
	logic          dir;
	logic [IW-1:0] child;
	logic          no_child;
	logic          is_full;
	logic [IW-1:0] new_node;
	logic          done;
	logic          adv;
	logic          alloc;
	logic          mark;
	logic          full_stop;
	status_t       res_st;
	logic [15:0]   res_pt;
	logic          left_we;
	logic          right_we;
	logic          has_we;
	logic          port_we;
	logic [IW-1:0] left_wd;
	logic [IW-1:0] right_wd;

	assign at_root  = (node_q == '0);
	// a node allocated earlier in this insert is not yet written: it reads as empty
	assign cur_left  = fresh_q ? '0 : (at_root ? root_left_q : rd_left_q);
	assign cur_right = fresh_q ? '0 : (at_root ? root_right_q : rd_right_q);
	assign cur_has   = fresh_q ? 1'b0 : (at_root ? root_has_q : rd_has_q);
	assign cur_port  = at_root ? root_port_q : rd_port_q;
	assign dir       = addr_q[ADDR_BITS-1];
	assign child     = dir ? cur_right : cur_left;
	assign no_child  = (child == '0);
	assign is_full   = (next_free_q == FULL_COUNT);
	assign new_node  = next_free_q[IW-1:0];

	always_comb begin
		done      = 1'b0;
		adv       = 1'b0;
		alloc     = 1'b0;
		mark      = 1'b0;
		full_stop = 1'b0;
		res_st    = ST_OK;
		res_pt    = '0;
		if (op_q == OP_INSERT) begin
			if (len_q > LEVEL_MAX) begin
				done   = 1'b1;
				res_st = ST_BAD_LENGTH;
			end else if (level_q == len_q) begin
				mark = 1'b1;
				done = 1'b1;
			end else if (!no_child) begin
				adv = 1'b1;
			end else if (is_full) begin
				full_stop = 1'b1;
				done      = 1'b1;
				res_st    = ST_TABLE_FULL;
			end else begin
				alloc = 1'b1;
			end
		end else begin
			if (cur_has || found_q) begin
				res_st = ST_OK;
				res_pt = cur_has ? cur_port : best_q;
			end else begin
				res_st = ST_NO_MATCH;
			end
			if ((level_q == LEVEL_MAX) || no_child) done = 1'b1;
			else adv = 1'b1;
		end
	end

	assign sts.done = done;

	// a fresh node gets its whole entry in one write, a linked node only its slot
	always_comb begin
		left_we  = cmd.walk && ((fresh_q && (alloc || full_stop || mark)) ||
			(alloc && !fresh_q && !at_root && !dir));
		right_we = cmd.walk && ((fresh_q && (alloc || full_stop || mark)) ||
			(alloc && !fresh_q && !at_root && dir));
		left_wd  = (alloc && !dir) ? new_node : '0;
		right_wd = (alloc && dir) ? new_node : '0;
		has_we   = cmd.walk && ((fresh_q && (alloc || full_stop)) || (mark && !at_root));
		port_we  = cmd.walk && mark && !at_root;
	end

	always_ff @(posedge clk) begin
		if (left_we) left_mem[node_q] <= left_wd;
		if (right_we) right_mem[node_q] <= right_wd;
		if (has_we) has_mem[node_q] <= mark;
		if (port_we) port_mem[node_q] <= hop_q;
		rd_left_q  <= left_mem[child];
		rd_right_q <= right_mem[child];
		rd_has_q   <= has_mem[child];
		rd_port_q  <= port_mem[child];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q       <= '0;
			level_q      <= '0;
			fresh_q      <= 1'b0;
			found_q      <= 1'b0;
			next_free_q  <= FW'(1);
			root_left_q  <= '0;
			root_right_q <= '0;
			root_has_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				node_q  <= '0;
				level_q <= '0;
				fresh_q <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.walk) begin
				if ((op_q == OP_LOOKUP) && cur_has) found_q <= 1'b1;
				if (adv) begin
					node_q  <= child;
					level_q <= level_q + 6'd1;
					fresh_q <= 1'b0;
				end
				if (alloc) begin
					node_q      <= new_node;
					level_q     <= level_q + 6'd1;
					fresh_q     <= 1'b1;
					next_free_q <= next_free_q + FW'(1);
					if (at_root && !fresh_q) begin
						if (dir) root_right_q <= new_node;
						else root_left_q <= new_node;
					end
				end
				if (mark && at_root) root_has_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			addr_q <= address;
			len_q  <= mask_len;
			hop_q  <= next_hop;
		end else if (cmd.walk) begin
			if ((op_q == OP_LOOKUP) && cur_has) best_q <= cur_port;
			if (adv || alloc) addr_q <= {addr_q[ADDR_BITS-2:0], 1'b0};
			if (mark && at_root) root_port_q <= hop_q;
			if (done) begin
				res_status_q <= res_st;
				res_port_q   <= res_pt;
			end
		end
		if (cmd.emit) begin
			status_q <= res_status_q;
			port_q   <= res_port_q;
		end
	end

	assign status     = status_q;
	assign port_found = port_q;

endmodule

### src/binary_trie_route_lookup.sv
// top level of the binary trie longest prefix match route table
//
// input channel (in_valid / in_stall) carries one transaction per lookup or
// insert: operation, address, mask_len and next_hop. output channel
// (out_valid / out_stall) returns exactly one status and port_found each.
// a transaction is taken when valid is high and stall is low at a clock edge.
// one item is in work at a time; the walk reads one trie node per cycle from
// the node store, and a finished walk leaves its status and port in a result
// register, which is copied to the output register as the block goes back to
// idle, ready to accept the next item.
// the result sits in an output register: a stalled result holds its value and
// the block still accepts the next item; a finished walk waits for that
// register to free up before it is handed over.
// reset clears the root node's links and match flag and sets the node counter
// to one; other nodes are initialized as they are allocated, so no clearing
// pass is needed and the block is ready as soon as reset is released.
`timescale 1ns / 1ps

module binary_trie_route_lookup import brt_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [31:0] address,
	input  logic [5:0]  mask_len,
	input  logic [15:0] next_hop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] port_found
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	brt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	brt_datapath #(
		.NODE_COUNT (NODE_COUNT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.operation  (operation),
		.address    (address),
		.mask_len   (mask_len),
		.next_hop   (next_hop),
		.status     (status),
		.port_found (port_found)
	);

endmodule

### src/brt_checker.sv
// port level checks for the trie route lookup, bound to the top level
`timescale 1ns / 1ps

module brt_checker import brt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        operation,
	input logic [31:0] address,
	input logic [5:0]  mask_len,
	input logic [15:0] next_hop,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [15:0] port_found
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(port_found))
		else $error("stalled result changed");

	// only an ok result carries a port
	a_port_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> port_found == 16'd0)
		else $error("port set on a non-ok result");

	// an accepted transaction keeps the block busy for its walk
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after acceptance");

	// a new result only comes out of a busy block
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a walk in progress");

endmodule

bind binary_trie_route_lookup brt_checker u_brt_checker (.*);
